// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: sv/fbd_pkg.sv
// Package for the page framebuffer draw engine: sizes, request codes,
// payload types and the controller/datapath command and status types.
// No dependencies.
package fbd_pkg;

   localparam int MAX_WIDTH   = 128;
   localparam int MAX_HEIGHT  = 64;
   localparam int PAGE_BITS   = 8;
   localparam int PAGES       = (MAX_HEIGHT + PAGE_BITS - 1) / PAGE_BITS;
   localparam int STORE_DEPTH = MAX_WIDTH * PAGES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int WIDE_W      = 14;
   localparam int PADDR_W     = 3;

   localparam logic [7:0] FRAME_WIDTH_RESET  = 8'd128;
   localparam logic [6:0] FRAME_HEIGHT_RESET = 7'd64;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [2:0] REQ_SET_PIXEL  = 3'd0;
   localparam logic [2:0] REQ_CLR_PIXEL  = 3'd1;
   localparam logic [2:0] REQ_FILL_AREA  = 3'd2;
   localparam logic [2:0] REQ_CLEAR_AREA = 3'd3;
   localparam logic [2:0] REQ_DRAW_ROW   = 3'd4;
   localparam logic [2:0] REQ_READ_BYTE  = 3'd5;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] area_w;
      logic [7:0] area_h;
      logic [7:0] row_bits;
      logic [9:0] byte_index;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       index_invalid;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic clr;
      logic rd;
      logic wr;
      logic next;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic is_draw;
      logic is_read;
      logic empty;
      logic idx_ok;
      logic last;
      logic clr_last;
   } dp_status_type;

endpackage

// File: sv/fbd_csr.sv
// Configuration registers of the draw engine on an APB-style port,
// with the clamped width and height used for drawing. Depends on fbd_pkg.
module fbd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fbd_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output logic [7:0]                  width_used,
   output logic [6:0]                  height_used
);
   import fbd_pkg::*;

   logic [7:0] frame_width_ff;
   logic [6:0] frame_height_ff;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (wr_en) begin
         if (paddr[2] == REG_FRAME_WIDTH) begin
            frame_width_ff <= pwdata[7:0];
         end else begin
            frame_height_ff <= pwdata[6:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? {25'd0, frame_height_ff}
                                                  : {24'd0, frame_width_ff};

   assign width_used  = ({1'b0, frame_width_ff} > 9'(MAX_WIDTH)) ?
                        8'(MAX_WIDTH) : frame_width_ff;
   assign height_used = ({2'b0, frame_height_ff} > 9'(MAX_HEIGHT)) ?
                        7'(MAX_HEIGHT) : frame_height_ff;

endmodule

// File: sv/fbd_ctrl.sv
// Controller state machine of the draw engine: clearing pass, request
// decode, read-modify-write walk and result handoff. Depends on fbd_pkg.
module fbd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fbd_pkg::dp_cmd_type    cmd,
   input  fbd_pkg::dp_status_type status
);
   import fbd_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_MEM_RD,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_draw && !status.empty) begin
               state_in = ST_RMW_RD;
            end else if (status.is_read && status.idx_ok) begin
               state_in = ST_MEM_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RMW_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            cmd.wr   = 1'b1;
            cmd.next = 1'b1;
            state_in = status.last ? ST_DONE : ST_RMW_RD;
         end
         ST_MEM_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/fbd_datapath.sv
// Datapath of the draw engine: request clipping, walk counters, the frame
// store with registered read, byte masking and the result register.
// Depends on fbd_pkg.
module fbd_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  fbd_pkg::req_payload_type req_data,
   output fbd_pkg::rsp_payload_type rsp_data,
   input  logic [7:0]               width_used,
   input  logic [6:0]               height_used,
   input  fbd_pkg::dp_cmd_type      cmd,
   output fbd_pkg::dp_status_type   status
);
   import fbd_pkg::*;

   logic [7:0] frame_store [STORE_DEPTH];

   logic [2:0]        kind_ff;
   logic [7:0]        x_ff, xs_ff, xe_ff;
   logic [4:0]        pg_ff, pf_ff, pl_ff;
   logic [2:0]        ylo_ff, yhi_ff;
   logic              empty_ff, idx_ok_ff;
   logic [7:0]        bits_ff;
   logic [9:0]        idx_ff;
   logic [7:0]        rdata_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   rsp_payload_type   rsp_data_ff;

   logic [7:0]        span_w, span_h, xe_in, ye_in, ye_m1;
   logic [8:0]        xe_sum, ye_sum;
   logic [7:0]        page_sum;
   logic [WIDE_W-1:0] limit, addr_full;
   logic              idx_ok_in;
   logic              is_draw, is_read, fill_on, row_mode, pix_on;
   logic [2:0]        lo, hi, col;
   logic [7:0]        mask, new_byte;
   logic [ADDR_W-1:0] draw_addr, rd_addr;
   rsp_payload_type   rsp_in;

   always_comb begin
      case (req_data.req_type)
         REQ_SET_PIXEL, REQ_CLR_PIXEL: begin
            span_w = 8'd1;
            span_h = 8'd1;
         end
         REQ_FILL_AREA, REQ_CLEAR_AREA: begin
            span_w = req_data.area_w;
            span_h = req_data.area_h;
         end
         REQ_DRAW_ROW: begin
            span_w = (req_data.area_w > 8'(PAGE_BITS)) ? 8'(PAGE_BITS) : req_data.area_w;
            span_h = 8'd1;
         end
         default: begin
            span_w = 8'd0;
            span_h = 8'd0;
         end
      endcase
   end

   assign xe_sum    = {1'b0, req_data.pos_x} + {1'b0, span_w};
   assign ye_sum    = {1'b0, req_data.pos_y} + {1'b0, span_h};
   assign xe_in     = (xe_sum > {1'b0, width_used}) ? width_used : xe_sum[7:0];
   assign ye_in     = (ye_sum > {2'b0, height_used}) ? {1'b0, height_used} : ye_sum[7:0];
   assign ye_m1     = ye_in - 8'd1;
   assign page_sum  = {1'b0, height_used} + 8'd7;
   assign limit     = WIDE_W'(width_used) * WIDE_W'(page_sum[7:3]);
   assign idx_ok_in = (WIDE_W'(req_data.byte_index) < limit) &&
                      (WIDE_W'(req_data.byte_index) < WIDE_W'(STORE_DEPTH));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_data.req_type;
         x_ff      <= req_data.pos_x;
         xs_ff     <= req_data.pos_x;
         xe_ff     <= xe_in;
         pg_ff     <= req_data.pos_y[7:3];
         pf_ff     <= req_data.pos_y[7:3];
         pl_ff     <= ye_m1[7:3];
         ylo_ff    <= req_data.pos_y[2:0];
         yhi_ff    <= ye_m1[2:0];
         empty_ff  <= (xe_in <= req_data.pos_x) || (ye_in <= req_data.pos_y);
         bits_ff   <= req_data.row_bits;
         idx_ff    <= req_data.byte_index;
         idx_ok_ff <= idx_ok_in;
      end else if (cmd.next) begin
         if (x_ff == xe_ff - 8'd1) begin
            x_ff  <= xs_ff;
            pg_ff <= pg_ff + 5'd1;
         end else begin
            x_ff <= x_ff + 8'd1;
         end
      end
   end

   always_comb begin
      case (kind_ff)
         REQ_SET_PIXEL, REQ_CLR_PIXEL, REQ_FILL_AREA, REQ_CLEAR_AREA, REQ_DRAW_ROW: begin
            is_draw = 1'b1;
         end
         default: begin
            is_draw = 1'b0;
         end
      endcase
   end

   assign is_read  = (kind_ff == REQ_READ_BYTE);
   assign fill_on  = (kind_ff == REQ_SET_PIXEL) || (kind_ff == REQ_FILL_AREA);
   assign row_mode = (kind_ff == REQ_DRAW_ROW);
   assign col      = 3'(x_ff - xs_ff);
   assign pix_on   = row_mode ? bits_ff[col] : fill_on;

   assign lo       = (pg_ff == pf_ff) ? ylo_ff : 3'd0;
   assign hi       = (pg_ff == pl_ff) ? yhi_ff : 3'd7;
   assign mask     = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
   assign new_byte = pix_on ? (rdata_ff | mask) : (rdata_ff & ~mask);

   assign addr_full = WIDE_W'(pg_ff) * WIDE_W'(width_used) + WIDE_W'(x_ff);
   assign draw_addr = addr_full[ADDR_W-1:0];
   assign rd_addr   = is_read ? ADDR_W'(idx_ff) : draw_addr;

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         frame_store[clr_cnt_ff] <= 8'd0;
      end else if (cmd.wr) begin
         frame_store[draw_addr] <= new_byte;
      end
      if (cmd.rd) begin
         rdata_ff <= frame_store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
      end
   end

   assign rsp_in.read_data     = (is_read && idx_ok_ff) ? rdata_ff : 8'd0;
   assign rsp_in.index_invalid = is_read && !idx_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_data        = rsp_data_ff;
   assign status.is_draw  = is_draw;
   assign status.is_read  = is_read;
   assign status.empty    = empty_ff;
   assign status.idx_ok   = idx_ok_ff;
   assign status.last     = (x_ff == xe_ff - 8'd1) && (pg_ff == pl_ff);
   assign status.clr_last = (clr_cnt_ff == ADDR_W'(STORE_DEPTH - 1));

endmodule

// File: sv/page_framebuffer_draw_engine.sv
// Page framebuffer draw engine: one request at a time, one result each.
// A draw reads and then writes each store byte that it touches, one
// access at a time on the single store port; a read of a valid index
// does one store read, and an invalid read or a fully clipped draw none.
// The next request is taken the cycle after the result is loaded.
// Synchronous reset clears the 1024-byte store, with req_stall high throughout.
module page_framebuffer_draw_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  fbd_pkg::req_payload_type    req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output fbd_pkg::rsp_payload_type    rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fbd_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import fbd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [7:0]    width_used;
   logic [6:0]    height_used;

   fbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .width_used  (width_used),
      .height_used (height_used)
   );

   fbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   fbd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .width_used  (width_used),
      .height_used (height_used),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// File: sv/fbd_checker.sv
// Port-level checks for the page framebuffer draw engine, bound to the top.
// Depends on fbd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input fbd_pkg::rsp_payload_type    rsp_data
);
   import fbd_pkg::*;

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled response changed")
   `ASSERT_CLK(a_clear_stall, clock, reset, $past(reset) |-> req_stall, "request taken during clearing pass")
   `ASSERT_CLK(a_one_at_a_time, clock, reset, req_valid && !req_stall |=> req_stall, "second transaction taken while busy")
   `ASSERT_NEVER(a_invalid_zero, clock, reset, rsp_valid && rsp_data.index_invalid && rsp_data.read_data != 8'd0, "invalid read carries data")

endmodule

bind page_framebuffer_draw_engine fbd_checker u_checker (.*);
